@@ hw/rtl/sorted_key_count_table_unit_assert.svh @@
// Assertion macros for the sorted key count table unit.
// Included by skct_seq, which checks its own sequencing; expects clk_i and rst_ni.
`ifndef SORTED_KEY_COUNT_TABLE_UNIT_ASSERT_SVH
`define SORTED_KEY_COUNT_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, inactive while in reset.
`define SKCT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, inactive while in reset.
`define SKCT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/skct_pkg.sv @@
// Shared types and constants for the sorted key count table unit.
// No dependencies; imported by skct_seq, the top module and the bench.
package skct_pkg;

  localparam int unsigned CAPACITY_DEF  = 256;
  localparam int unsigned KEY_BYTES_DEF = 8;
  localparam int unsigned KEY_W         = 64;
  localparam int unsigned COUNT_W       = 32;
  localparam int unsigned FILL_W        = 9;
  localparam int unsigned REQ_W         = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FIND   = 2'd2;

  typedef enum logic [2:0] {
    ST_BUMPED    = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef struct packed {
    status_e              status;
    logic                 found;
    logic [COUNT_W-1:0]   count;
    logic [FILL_W-1:0]    fill_level;
  } res_t;

endpackage

@@ hw/rtl/sorted_key_count_table_unit.sv @@
// Sorted key count table: one request in, one result out, per stream request.
// A find or bump runs a binary search over the n keys held, then a hit check;
// insert and delete also shift the entries moved, through one memory port pair.
// One request at a time: a new request is taken only after the last result is handed on.
// Reset (rst_ni low, asynchronous) empties the table; the table memory itself is not cleared.
module sorted_key_count_table_unit import skct_pkg::*; #(
  parameter int unsigned CAPACITY  = CAPACITY_DEF,
  parameter int unsigned KEY_BYTES = KEY_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [63:0] key
  input  logic [1:0]  s_axis_tuser,  // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // [31:0] count, [40:32] fill_level, [47:41] zero
  output logic [3:0]  m_axis_tuser   // [2:0] status, [3] found
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned DW = 8 * KEY_BYTES + COUNT_W;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdata, mem_rdata;
  logic          res_valid, res_ready;
  res_t          res;

  logic          out_valid_q, out_valid_d;
  res_t          out_res_q, out_res_d;

  skct_seq #(
    .CAPACITY  (CAPACITY),
    .KEY_BYTES (KEY_BYTES)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_type_i  (s_axis_tuser),
    .req_key_i   (s_axis_tdata),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  skct_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (DW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register: a finished result waits here while the sequencer goes idle
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_res_d   = res;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      out_res_q   <= out_res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_res_q.fill_level, out_res_q.count};
  assign m_axis_tuser  = {out_res_q.found, out_res_q.status};

endmodule

@@ hw/rtl/skct_mem.sv @@
// Simple dual-port table memory: one write and one registered read per cycle.
// Depends on nothing but its parameters.
module skct_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 96,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/skct_seq.sv @@
// Request sequencer: binary search, hit check, entry shifting and result build.
// Depends on skct_pkg and drives the table memory skct_mem.
`include "sorted_key_count_table_unit_assert.svh"

module skct_seq import skct_pkg::*; #(
  parameter int unsigned CAPACITY  = CAPACITY_DEF,
  parameter int unsigned KEY_BYTES = KEY_BYTES_DEF,
  localparam int unsigned AW = $clog2(CAPACITY),
  localparam int unsigned CW = $clog2(CAPACITY + 1),
  localparam int unsigned KW = 8 * KEY_BYTES,
  localparam int unsigned DW = KW + COUNT_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  logic [REQ_W-1:0] req_type_i,
  input  logic [KEY_W-1:0] req_key_i,
  output logic             mem_we_o,
  output logic [AW-1:0]    mem_waddr_o,
  output logic [DW-1:0]    mem_wdata_o,
  output logic [AW-1:0]    mem_raddr_o,
  input  logic [DW-1:0]    mem_rdata_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output res_t             res_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_SCMP,
    S_HCHK,
    S_DECIDE,
    S_SHIFT,
    S_PUT,
    S_OUT
  } state_e;

  state_e             state_q, state_d;
  logic [REQ_W-1:0]   req_q, req_d;
  logic [KW-1:0]      key_q, key_d;
  logic [CW-1:0]      lo_q, lo_d, hi_q, hi_d, used_q, used_d, rem_q, rem_d;
  logic [AW-1:0]      mid_q, mid_d, ptr_q, ptr_d, last_q, last_d;
  logic               hit_q, hit_d, pend_q, pend_d, up_q, up_d;
  logic [COUNT_W-1:0] held_q, held_d;
  res_t               res_q, res_d;

  logic [CW:0]        sum_w;
  logic [CW-1:0]      mid_full;
  logic [KW-1:0]      rd_key;
  logic [COUNT_W-1:0] rd_cnt, bump_cnt;
  logic [CW-1:0]      used_dec, pos_inc;

  assign sum_w    = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_full = sum_w[CW:1];
  assign rd_key   = mem_rdata_i[DW-1 -: KW];
  assign rd_cnt   = mem_rdata_i[COUNT_W-1:0];
  assign bump_cnt = (held_q == COUNT_MAX) ? held_q : held_q + COUNT_W'(1);
  assign used_dec = used_q - CW'(1);
  assign pos_inc  = lo_q + CW'(1);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    key_d       = key_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    used_d      = used_q;
    rem_d       = rem_q;
    mid_d       = mid_q;
    ptr_d       = ptr_q;
    last_d      = last_q;
    hit_d       = hit_q;
    pend_d      = pend_q;
    up_d        = up_q;
    held_d      = held_q;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = lo_q[AW-1:0];
    mem_wdata_o = {key_q, bump_cnt};
    mem_raddr_o = mid_full[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          req_d   = req_type_i;
          key_d   = req_key_i[KEY_W-1 -: KW];
          lo_d    = '0;
          hi_d    = used_q;
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        if (lo_q < hi_q) begin
          mem_raddr_o = mid_full[AW-1:0];
          mid_d       = mid_full[AW-1:0];
          state_d     = S_SCMP;
        end else if (lo_q < used_q) begin
          mem_raddr_o = lo_q[AW-1:0];
          state_d     = S_HCHK;
        end else begin
          hit_d   = 1'b0;
          state_d = S_DECIDE;
        end
      end
      S_SCMP: begin
        if (rd_key < key_q) begin
          lo_d = CW'(mid_q) + CW'(1);
        end else begin
          hi_d = CW'(mid_q);
        end
        state_d = S_SRCH;
      end
      S_HCHK: begin
        hit_d   = (rd_key == key_q);
        held_d  = rd_cnt;
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        state_d = S_OUT;
        case (req_q)
          REQ_INSERT: begin
            if (hit_q) begin
              mem_we_o = 1'b1;
              res_d    = '{ST_BUMPED, 1'b1, bump_cnt, FILL_W'(used_q)};
            end else if (used_q == CW'(CAPACITY)) begin
              res_d = '{ST_FULL, 1'b0, '0, FILL_W'(used_q)};
            end else begin
              // open a gap: move entries [pos, used) up by one, top first
              up_d    = 1'b1;
              rem_d   = used_q - lo_q;
              ptr_d   = used_dec[AW-1:0];
              pend_d  = 1'b0;
              state_d = S_SHIFT;
            end
          end
          REQ_DELETE: begin
            if (hit_q) begin
              up_d    = 1'b0;
              rem_d   = used_dec - lo_q;
              ptr_d   = pos_inc[AW-1:0];
              pend_d  = 1'b0;
              state_d = S_SHIFT;
            end else begin
              res_d = '{ST_NOT_FOUND, 1'b0, '0, FILL_W'(used_q)};
            end
          end
          default: begin
            if (hit_q) begin
              res_d = '{ST_BUMPED, 1'b1, held_q, FILL_W'(used_q)};
            end else begin
              res_d = '{ST_NOT_FOUND, 1'b0, '0, FILL_W'(used_q)};
            end
          end
        endcase
      end
      S_SHIFT: begin
        // read one entry per cycle, write it back one slot over in the next cycle
        if (pend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = up_q ? last_q + AW'(1) : last_q - AW'(1);
          mem_wdata_o = mem_rdata_i;
        end
        if (rem_q != '0) begin
          mem_raddr_o = ptr_q;
          last_d      = ptr_q;
          ptr_d       = up_q ? ptr_q - AW'(1) : ptr_q + AW'(1);
          rem_d       = rem_q - CW'(1);
          pend_d      = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = S_PUT;
          end
        end
      end
      S_PUT: begin
        state_d = S_OUT;
        if (up_q) begin
          mem_we_o    = 1'b1;
          mem_wdata_o = {key_q, COUNT_W'(1)};
          used_d      = used_q + CW'(1);
          res_d       = '{ST_INSERTED, 1'b0, COUNT_W'(1), FILL_W'(used_q + CW'(1))};
        end else begin
          used_d = used_dec;
          res_d  = '{ST_DELETED, 1'b1, '0, FILL_W'(used_dec)};
        end
      end
      S_OUT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      req_q   <= '0;
      key_q   <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      used_q  <= '0;
      rem_q   <= '0;
      mid_q   <= '0;
      ptr_q   <= '0;
      last_q  <= '0;
      hit_q   <= 1'b0;
      pend_q  <= 1'b0;
      up_q    <= 1'b0;
      held_q  <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      req_q   <= req_d;
      key_q   <= key_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      used_q  <= used_d;
      rem_q   <= rem_d;
      mid_q   <= mid_d;
      ptr_q   <= ptr_d;
      last_q  <= last_d;
      hit_q   <= hit_d;
      pend_q  <= pend_d;
      up_q    <= up_d;
      held_q  <= held_d;
      res_q   <= res_d;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_OUT);
  assign res_o       = res_q;

  `SKCT_ASSERT_IMP(a_used_bound, 1'b1, used_q <= CW'(CAPACITY), "fill count above capacity")
  `SKCT_ASSERT_IMP(a_waddr_bound, mem_we_o, CW'(mem_waddr_o) < CW'(CAPACITY), "write beyond table")
  `SKCT_ASSERT_IMP(a_search_window, state_q == S_SRCH, (lo_q <= hi_q) && (hi_q <= used_q),
                   "search window out of order")
  `SKCT_ASSERT_IMP(a_find_no_write, (state_q == S_DECIDE) && (req_q != REQ_INSERT), !mem_we_o,
                   "find or delete wrote the table while deciding")
  `SKCT_ASSERT_NXT(a_back_to_idle, res_valid_o && res_ready_i, req_ready_o,
                   "sequencer not idle after result handoff")

endmodule

@@ verif/sorted_key_count_table_unit_test.sv @@
// Self-checking bench for the sorted key count table unit: streams insert, delete
// and find requests and checks every result against a behavioural table model.
// Depends on skct_pkg and the sorted_key_count_table_unit RTL.
module sorted_key_count_table_unit_test;
  import skct_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // request code the block treats as a find
  localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
  localparam int unsigned FILL_KEYS = 270;
  localparam int unsigned POOL_KEYS = 48;
  localparam int unsigned RAND_REQS = 280;

  typedef struct packed {
    logic [REQ_W-1:0] kind;
    logic [KEY_W-1:0] key;
  } table_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // [63:0] key
  logic [1:0]  s_axis_tuser = '0;   // [1:0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // [31:0] count, [40:32] fill_level, [47:41] zero
  logic [3:0]  m_axis_tuser;        // [2:0] status, [3] found

  sorted_key_count_table_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("FAIL");
    $finish;
  end

  // Table model
  logic [KEY_W-1:0]   key_tbl [CAPACITY_DEF];
  logic [COUNT_W-1:0] cnt_tbl [CAPACITY_DEF];
  int unsigned        keys_held = 0;

  table_req_t  requests_to_send [$];
  res_t        answers_due [$];
  int unsigned err_count = 0;
  int unsigned results_seen = 0;

  task automatic table_lookup_update(input table_req_t rq, output res_t res);
    int unsigned slot;
    bit          hit;
    slot = 0;
    while (slot < keys_held && key_tbl[slot] < rq.key) slot++;
    hit = (slot < keys_held) && (key_tbl[slot] == rq.key);
    res = '0;
    res.found = hit;
    case (rq.kind)
      REQ_INSERT: begin
        if (hit) begin
          if (cnt_tbl[slot] != COUNT_MAX) cnt_tbl[slot] = cnt_tbl[slot] + 1;
          res.count = cnt_tbl[slot];
          res.status = ST_BUMPED;
        end else if (keys_held >= CAPACITY_DEF) begin
          res.status = ST_FULL;
        end else begin
          for (int j = keys_held; j > slot; j--) begin
            key_tbl[j] = key_tbl[j-1];
            cnt_tbl[j] = cnt_tbl[j-1];
          end
          key_tbl[slot] = rq.key;
          cnt_tbl[slot] = 1;
          keys_held++;
          res.count = 1;
          res.status = ST_INSERTED;
        end
      end
      REQ_DELETE: begin
        if (hit) begin
          for (int j = slot; j + 1 < keys_held; j++) begin
            key_tbl[j] = key_tbl[j+1];
            cnt_tbl[j] = cnt_tbl[j+1];
          end
          keys_held--;
          res.status = ST_DELETED;
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      default: begin
        if (hit) begin
          res.count = cnt_tbl[slot];
          res.status = ST_BUMPED;
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
    endcase
    res.fill_level = keys_held[FILL_W-1:0];
  endtask

  // mostly short gaps, a few long ones; none at all in quiet stretches
  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // Request driver
  table_req_t  drv_cur, drv_next;
  res_t        drv_due;
  int unsigned gap_left = 0;
  int unsigned items_sent = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      gap_left      <= 0;
      items_sent    <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        drv_cur.kind = s_axis_tuser;
        drv_cur.key  = s_axis_tdata;
        table_lookup_update(drv_cur, drv_due);
        answers_due.push_back(drv_due);
      end
      if (gap_left != 0) begin
        gap_left      <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (requests_to_send.size() != 0) begin
        drv_next = requests_to_send.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= drv_next.key;
        s_axis_tuser  <= drv_next.kind;
        items_sent    <= items_sent + 1;
        gap_left      <= pick_gap(items_sent[6]);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result back-pressure: random stalls plus one long hold-off
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
      hold_left     <= 0;
      hold_done     <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && results_seen >= 150) begin
      hold_left     <= 2500;
      hold_done     <= 1'b1;
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (results_seen[5] == 1'b0 && $urandom_range(0, 3) == 0) begin
      stall_left    <= pick_gap(1'b0);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Result monitor
  res_t want;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (answers_due.size() == 0) begin
        report_mismatch("result with no request due", {16'd0, m_axis_tdata}, '0);
      end else begin
        want = answers_due.pop_front();
        if (m_axis_tuser[2:0] !== want.status)
          report_mismatch("status", 64'(m_axis_tuser[2:0]), 64'(want.status));
        if (m_axis_tuser[3] !== want.found)
          report_mismatch("found", 64'(m_axis_tuser[3]), 64'(want.found));
        if (m_axis_tdata[31:0] !== want.count)
          report_mismatch("count", 64'(m_axis_tdata[31:0]), 64'(want.count));
        if (m_axis_tdata[40:32] !== want.fill_level)
          report_mismatch("fill_level", 64'(m_axis_tdata[40:32]), 64'(want.fill_level));
      end
      results_seen <= results_seen + 1;
    end
  end

  task automatic queue_request(input logic [REQ_W-1:0] kind, input logic [KEY_W-1:0] key);
    table_req_t rq;
    rq.kind = kind;
    rq.key  = key;
    requests_to_send.push_back(rq);
  endtask

  // sender holds back until every request has been answered
  task automatic wait_idle();
    while (requests_to_send.size() != 0 || s_axis_tvalid || answers_due.size() != 0)
      @(negedge clk_i);
  endtask

  // lower-case word of len letters, first letter in the top byte
  function automatic logic [KEY_W-1:0] pack_word(input int unsigned len);
    logic [KEY_W-1:0] w;
    w = '0;
    for (int b = 0; b < 8; b++)
      if (b < len) w[63-8*b -: 8] = 8'h61 + 8'($urandom_range(0, 25));
    return w;
  endfunction

  initial begin
    logic [KEY_W-1:0] fill_keys [FILL_KEYS];
    logic [KEY_W-1:0] key_pool [POOL_KEYS];
    logic [KEY_W-1:0] k;
    logic [REQ_W-1:0] op;
    int unsigned      r;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, extremes of the key, bump, both find codes, delete hit and miss
    queue_request(REQ_FIND,   '0);
    queue_request(REQ_DELETE, '0);
    queue_request(REQ_INSERT, '0);
    queue_request(REQ_INSERT, '1);
    queue_request(REQ_INSERT, '0);
    queue_request(REQ_INSERT, {"cat", 40'd0});
    queue_request(REQ_INSERT, {"apple", 24'd0});
    queue_request(REQ_INSERT, {"zebra", 24'd0});
    queue_request(REQ_INSERT, "abcdefgh");
    queue_request(REQ_INSERT, {"apple", 24'd0});
    queue_request(REQ_FIND,   {"apple", 24'd0});
    queue_request(REQ_SPARE,  {"cat", 40'd0});
    queue_request(REQ_SPARE,  {"dog", 40'd0});
    queue_request(REQ_DELETE, {"apple", 24'd0});
    queue_request(REQ_DELETE, {"apple", 24'd0});
    queue_request(REQ_FIND,   {"apple", 24'd0});
    queue_request(REQ_FIND,   '1);
    queue_request(REQ_DELETE, '0);
    queue_request(REQ_DELETE, '1);
    queue_request(REQ_FIND,   '0);
    queue_request(REQ_INSERT, 64'h8000_0000_0000_0000);
    queue_request(REQ_INSERT, 64'h0000_0000_0000_0001);
    wait_idle();

    // fill past capacity, then bump, find and insert while full, delete one and refill
    for (int i = 0; i < FILL_KEYS; i++) begin
      fill_keys[i] = {$urandom, $urandom};
      queue_request(REQ_INSERT, fill_keys[i]);
    end
    queue_request(REQ_INSERT, fill_keys[3]);
    queue_request(REQ_FIND,   fill_keys[100]);
    queue_request(REQ_INSERT, {$urandom, $urandom});
    queue_request(REQ_DELETE, fill_keys[0]);
    queue_request(REQ_INSERT, {$urandom, $urandom});
    queue_request(REQ_INSERT, {$urandom, $urandom});
    wait_idle();

    // drain in scattered order; keys refused while full come back as misses
    for (int i = 0; i < FILL_KEYS; i++)
      queue_request(REQ_DELETE, fill_keys[(i * 7) % FILL_KEYS]);
    wait_idle();

    for (int i = 0; i < POOL_KEYS; i++) begin
      if (i == 0) key_pool[i] = '0;
      else if (i == 1) key_pool[i] = '1;
      else if (i % 3 == 0) key_pool[i] = {$urandom, $urandom};
      else key_pool[i] = pack_word($urandom_range(1, 8));
    end

    for (int i = 0; i < RAND_REQS; i++) begin
      if (i == RAND_REQS / 2) wait_idle();
      r = $urandom_range(0, 99);
      if (r < 50) op = REQ_INSERT;
      else if (r < 70) op = REQ_DELETE;
      else if (r < 95) op = REQ_FIND;
      else op = REQ_SPARE;
      if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, POOL_KEYS - 1)];
      else k = {$urandom, $urandom};
      queue_request(op, k);
    end

    wait_idle();
    repeat (400) @(posedge clk_i);
    if (err_count == 0 && answers_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
